>>> design/melody_tone_sequencer_defines.svh
// Assertion macros used by the melody tone sequencer top module.
// No dependencies; included by the files that carry assertions.
`ifndef MELODY_TONE_SEQUENCER_DEFINES_SVH
`define MELODY_TONE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define MTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mts assertion failed");

// Next-cycle implication, disabled while in reset
`define MTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mts assertion failed");

`endif

>>> design/mts_pkg.sv
// Types, constants and the pitch table of the melody tone sequencer.
// No dependencies; used by mts_step, melody_tone_sequencer and the testbench.
package mts_pkg;

    localparam int DEFAULT_SCORE_DEPTH = 256;
    localparam int DEFAULT_NOTE_COUNT  = 61;
    localparam int ENTRY_WIDTH         = 16;

    localparam logic [7:0]  END_MARK          = 8'hFF;
    localparam logic [15:0] CYCLES_PER_MS_RST = 16'd1000;
    localparam logic [15:0] UNIT_MS_RST       = 16'd250;
    localparam logic [7:0]  GAP_MS_RST        = 8'd5;

    // Input command codes
    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_RESTART = 3'd1,
        OP_PAUSE   = 3'd2,
        OP_RESUME  = 3'd3,
        OP_LOAD    = 3'd4
    } op_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_CYCLES_PER_MS = 2'd0,
        CFG_UNIT_MS       = 2'd1,
        CFG_GAP_MS        = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_NOTE  = 2'd1,
        PH_GAP   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] load_addr;
        logic [7:0] load_note;
        logic [7:0] load_length;
    } in_word_t;

    typedef struct packed {
        logic       buzzer;
        logic       tone_on;
        logic [7:0] position;
        logic       finished;
    } out_word_t;

    typedef struct packed {
        logic [15:0] cycles_per_ms;
        logic [15:0] unit_ms;
        logic [7:0]  gap_ms;
    } cfg_t;

    // Playback state carried between words
    typedef struct packed {
        logic [7:0]  pos;
        logic [5:0]  note_sel;
        logic [15:0] half_cnt;
        logic [15:0] ms_cyc;
        logic [15:0] ms_cnt;
        logic [7:0]  unit_cnt;
        phase_t      phase;
        logic        paused;
        logic        wave;
        logic        ended;
    } play_t;

    // Timer reload values per pitch code; code 0 and codes past 60 never toggle
    localparam logic [15:0] RELOAD_TABLE [64] = '{
        16'd0,     16'd61719, 16'd61939, 16'd62135, 16'd62331, 16'd62506,
        16'd62679, 16'd62833, 16'd62985, 16'd63132, 16'd63263, 16'd63390,
        16'd63512, 16'd63628, 16'd63731, 16'd63835, 16'd63928, 16'd64021,
        16'd64103, 16'd64185, 16'd64260, 16'd64331, 16'd64400, 16'd64463,
        16'd64524, 16'd64580, 16'd64633, 16'd64684, 16'd64732, 16'd64777,
        16'd64820, 16'd64860, 16'd64898, 16'd64934, 16'd64968, 16'd65000,
        16'd65030, 16'd65058, 16'd65085, 16'd65110, 16'd65134, 16'd65157,
        16'd65178, 16'd65198, 16'd65217, 16'd65235, 16'd65252, 16'd65268,
        16'd65283, 16'd65297, 16'd65310, 16'd65323, 16'd65335, 16'd65346,
        16'd65357, 16'd65367, 16'd65377, 16'd65385, 16'd65394, 16'd65402,
        16'd65409, 16'd0,     16'd0,     16'd0
    };

    // Half period in ticks: 65536 minus the reload value
    function automatic logic [16:0] half_period(logic [5:0] sel);
        half_period = 17'h10000 - {1'b0, RELOAD_TABLE[sel]};
    endfunction

endpackage

>>> design/mts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the score entries.
module mts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; returns old data on a same-address write
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> design/mts_step.sv
// Next playback state for one accepted word: tone, millisecond and unit timers.
// Depends on mts_pkg.
module mts_step #(
    parameter int NOTE_COUNT = mts_pkg::DEFAULT_NOTE_COUNT
) (
    input  mts_pkg::play_t    play,
    input  mts_pkg::cfg_t     cfg,
    input  mts_pkg::in_word_t word,
    input  logic [15:0]       entry,
    output mts_pkg::play_t    play_next
);
    import mts_pkg::*;

    logic [16:0] hp;
    logic [15:0] half_inc;
    logic [15:0] ms_cyc_inc;
    logic        ms_done;
    logic [15:0] ms_inc;
    logic [7:0]  unit_inc;
    logic [7:0]  entry_note;
    logic [7:0]  entry_len;

    // Shared increments and compares
    always_comb
    begin
        hp         = half_period(play.note_sel);
        half_inc   = play.half_cnt + 16'd1;
        ms_cyc_inc = play.ms_cyc + 16'd1;
        ms_done    = (ms_cyc_inc >= cfg.cycles_per_ms) || (ms_cyc_inc == 16'd0);
        ms_inc     = play.ms_cnt + 16'd1;
        unit_inc   = play.unit_cnt + 8'd1;
        entry_note = entry[15:8];
        entry_len  = entry[7:0];
    end

    // Command decode and timer sequencing
    always_comb
    begin
        play_next = play;
        case (word.op)
            OP_TICK:
            begin
                if (!play.ended && !play.paused)
                begin
                    case (play.phase)
                        PH_START:
                        begin
                            if (entry_note == END_MARK)
                            begin
                                play_next.ended = 1'b1;
                            end
                            else
                            begin
                                // unknown codes play as a rest
                                play_next.note_sel = (32'(entry_note) < NOTE_COUNT &&
                                                      entry_note < 8'd64) ?
                                                     entry_note[5:0] : 6'd0;
                                play_next.half_cnt = 16'd0;
                                play_next.ms_cyc   = 16'd0;
                                play_next.ms_cnt   = 16'd0;
                                play_next.unit_cnt = 8'd0;
                                play_next.phase    = (entry_len == 8'd0) ? PH_GAP : PH_NOTE;
                            end
                        end
                        PH_NOTE:
                        begin
                            // square wave, not for a rest
                            if (play.note_sel != 6'd0)
                            begin
                                if ({1'b0, half_inc} >= hp)
                                begin
                                    play_next.half_cnt = 16'd0;
                                    play_next.wave     = ~play.wave;
                                end
                                else
                                begin
                                    play_next.half_cnt = half_inc;
                                end
                            end
                            // note duration
                            if (ms_done)
                            begin
                                play_next.ms_cyc = 16'd0;
                                if (ms_inc >= cfg.unit_ms || ms_inc == 16'd0)
                                begin
                                    play_next.ms_cnt   = 16'd0;
                                    play_next.unit_cnt = unit_inc;
                                    if (unit_inc >= entry_len)
                                    begin
                                        play_next.half_cnt = 16'd0;
                                        play_next.unit_cnt = 8'd0;
                                        play_next.phase    = PH_GAP;
                                    end
                                end
                                else
                                begin
                                    play_next.ms_cnt = ms_inc;
                                end
                            end
                            else
                            begin
                                play_next.ms_cyc = ms_cyc_inc;
                            end
                        end
                        default:
                        begin
                            // silent gap, then the next entry
                            if (play.ms_cnt >= {8'd0, cfg.gap_ms})
                            begin
                                play_next.half_cnt = 16'd0;
                                play_next.ms_cyc   = 16'd0;
                                play_next.ms_cnt   = 16'd0;
                                play_next.unit_cnt = 8'd0;
                                play_next.pos      = play.pos + 8'd1;
                                play_next.phase    = PH_START;
                            end
                            else if (ms_done)
                            begin
                                play_next.ms_cyc = 16'd0;
                                play_next.ms_cnt = ms_inc;
                            end
                            else
                            begin
                                play_next.ms_cyc = ms_cyc_inc;
                            end
                        end
                    endcase
                end
            end
            OP_RESTART:
            begin
                if (!play.ended && !play.paused)
                begin
                    play_next.pos      = 8'd0;
                    play_next.note_sel = 6'd0;
                    play_next.half_cnt = 16'd0;
                    play_next.ms_cyc   = 16'd0;
                    play_next.ms_cnt   = 16'd0;
                    play_next.unit_cnt = 8'd0;
                    play_next.phase    = PH_START;
                end
            end
            OP_PAUSE:
            begin
                if (!play.ended)
                begin
                    play_next.paused = 1'b1;
                end
            end
            OP_RESUME:
            begin
                if (!play.ended)
                begin
                    play_next.paused = 1'b0;
                end
            end
            default:
            begin
                // load is handled by the score memory; other codes are no-ops
                play_next = play;
            end
        endcase
    end

endmodule

>>> design/melody_tone_sequencer.sv
// A word accepted at one edge has its result word registered and valid after that edge.
// One word per cycle while in_stall is low; the score memory is read each cycle at the next position.
// The output register holds a valid result while out_stall is high; in_stall is out_stall while a result is valid.
// Reset clears playback state and output valid, and sets config (cycles_per_ms 1000, unit 250 ms, gap 5 ms).
// Score memory contents are undefined after reset until loaded.
// Depends on mts_pkg, mts_ram, mts_step and melody_tone_sequencer_defines.svh.
`include "melody_tone_sequencer_defines.svh"

module melody_tone_sequencer #(
    parameter int SCORE_DEPTH = mts_pkg::DEFAULT_SCORE_DEPTH,
    parameter int NOTE_COUNT  = mts_pkg::DEFAULT_NOTE_COUNT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mts_pkg::in_word_t   in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output mts_pkg::out_word_t  out_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import mts_pkg::*;

    localparam int AW = $clog2(SCORE_DEPTH);

    cfg_t      cfg_reg;
    play_t     play_reg;
    play_t     play_step;
    play_t     play_next;
    out_word_t out_reg;
    out_word_t out_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    logic      accept;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [ENTRY_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [ENTRY_WIDTH-1:0] ram_rdata;
    logic                   fwd_valid_reg;
    logic [ENTRY_WIDTH-1:0] fwd_data_reg;
    logic [ENTRY_WIDTH-1:0] entry;

    // Handshake
    assign accept    = in_valid && !in_stall;
    assign in_stall  = out_valid_reg && out_stall;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cycles_per_ms <= CYCLES_PER_MS_RST;
            cfg_reg.unit_ms       <= UNIT_MS_RST;
            cfg_reg.gap_ms        <= GAP_MS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CYCLES_PER_MS: cfg_reg.cycles_per_ms <= cfg_data;
                CFG_UNIT_MS:       cfg_reg.unit_ms       <= cfg_data;
                CFG_GAP_MS:        cfg_reg.gap_ms        <= cfg_data[7:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // Score memory: load port and read at the upcoming position
    assign ram_we    = accept && (in_word.op == OP_LOAD) &&
                       (32'(in_word.load_addr) < SCORE_DEPTH);
    assign ram_waddr = AW'(in_word.load_addr);
    assign ram_wdata = {in_word.load_note, in_word.load_length};
    assign ram_raddr = AW'(play_next.pos);

    mts_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (SCORE_DEPTH)
    ) u_score (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Forward a load that hits the address being read in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= ram_we && (ram_waddr == ram_raddr);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= ram_wdata;
    end

    // Entry at the current position; past the end of the memory it is the end mark
    always_comb
    begin
        if (32'(play_reg.pos) < SCORE_DEPTH)
        begin
            entry = fwd_valid_reg ? fwd_data_reg : ram_rdata;
        end
        else
        begin
            entry = {END_MARK, 8'd0};
        end
    end

    mts_step #(
        .NOTE_COUNT (NOTE_COUNT)
    ) u_step (
        .play      (play_reg),
        .cfg       (cfg_reg),
        .word      (in_word),
        .entry     (entry),
        .play_next (play_step)
    );

    assign play_next = accept ? play_step : play_reg;

    // Playback state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            play_reg <= '{pos: 8'd0, note_sel: 6'd0, half_cnt: 16'd0, ms_cyc: 16'd0,
                          ms_cnt: 16'd0, unit_cnt: 8'd0, phase: PH_START,
                          paused: 1'b0, wave: 1'b0, ended: 1'b0};
        end
        else
        begin
            play_reg <= play_next;
        end
    end

    // Result word from the updated state
    always_comb
    begin
        out_next.buzzer   = play_step.wave;
        out_next.tone_on  = !play_step.ended && !play_step.paused &&
                            (play_step.phase == PH_NOTE) && (play_step.note_sel != 6'd0);
        out_next.position = play_step.pos;
        out_next.finished = play_step.ended;
        out_valid_next    = accept || (out_valid_reg && out_stall);
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    // Checks
    `MTS_ASSERT_NEXT(a_end_sticks, clk, rst_n, play_reg.ended, play_reg.ended)
    `MTS_ASSERT_NEXT(a_pause_freezes, clk, rst_n,
        accept && play_reg.paused && in_word.op != OP_RESUME, $stable(play_reg))
    `MTS_ASSERT_IMPL(a_rest_no_count, clk, rst_n,
        play_reg.note_sel == 6'd0, play_reg.half_cnt == 16'd0)
    `MTS_ASSERT_IMPL(a_tone_not_done, clk, rst_n,
        out_valid_reg && out_reg.tone_on, !out_reg.finished)
    `MTS_ASSERT_NEXT(a_accept_result, clk, rst_n, accept, out_valid_reg)

endmodule

>>> dv/melody_tone_sequencer_test.sv
`timescale 1ns / 1ps
// Testbench for melody_tone_sequencer: random and directed command words, checked
// word by word against a cycle-exact playback predictor. Depends on mts_pkg and the RTL.
module melody_tone_sequencer_test;
    import mts_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 4;
    localparam int STORE_DEPTH  = 256;

    // Op codes the block ignores
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // Note codes
    localparam logic [7:0] NOTE_REST        = 8'h00;
    localparam logic [7:0] NOTE_PITCH_LO    = 8'd1;
    localparam logic [7:0] NOTE_PITCH_HI    = 8'd60;
    localparam logic [7:0] NOTE_UNKNOWN_HI  = 8'd254;

    // Timer reload per pitch; half period is 65536 minus this
    localparam logic [15:0] PITCH_RELOAD [64] = '{
        16'd0,     16'd61719, 16'd61939, 16'd62135, 16'd62331, 16'd62506,
        16'd62679, 16'd62833, 16'd62985, 16'd63132, 16'd63263, 16'd63390,
        16'd63512, 16'd63628, 16'd63731, 16'd63835, 16'd63928, 16'd64021,
        16'd64103, 16'd64185, 16'd64260, 16'd64331, 16'd64400, 16'd64463,
        16'd64524, 16'd64580, 16'd64633, 16'd64684, 16'd64732, 16'd64777,
        16'd64820, 16'd64860, 16'd64898, 16'd64934, 16'd64968, 16'd65000,
        16'd65030, 16'd65058, 16'd65085, 16'd65110, 16'd65134, 16'd65157,
        16'd65178, 16'd65198, 16'd65217, 16'd65235, 16'd65252, 16'd65268,
        16'd65283, 16'd65297, 16'd65310, 16'd65323, 16'd65335, 16'd65346,
        16'd65357, 16'd65367, 16'd65377, 16'd65385, 16'd65394, 16'd65402,
        16'd65409, 16'd0,     16'd0,     16'd0
    };

    // Playback predictor and queue of expected result words
    class melody_scoreboard;
        logic [15:0] cycles_per_ms;
        logic [15:0] unit_ms;
        logic [7:0]  gap_ms;
        logic [15:0] score [STORE_DEPTH];
        bit          loaded [STORE_DEPTH];
        logic [7:0]  pos;
        logic [5:0]  note_sel;
        logic [15:0] half_cnt;
        logic [15:0] ms_cyc;
        logic [15:0] ms_cnt;
        logic [7:0]  unit_cnt;
        phase_t      phase;
        bit          paused;
        bit          wave;
        bit          ended;
        out_word_t   expected_words [$];
        int          errors;

        function new();
            // register reset values
            cycles_per_ms = 16'd1000;
            unit_ms       = 16'd250;
            gap_ms        = 8'd5;
            foreach (loaded[i]) loaded[i] = 1'b0;
            pos      = '0;
            note_sel = '0;
            phase    = PH_START;
            paused   = 1'b0;
            wave     = 1'b0;
            ended    = 1'b0;
            errors   = 0;
            clear_counters();
        endfunction

        function void set_reg(cfg_index_t idx, logic [15:0] val);
            case (idx)
                CFG_CYCLES_PER_MS: cycles_per_ms = val;
                CFG_UNIT_MS:       unit_ms = val;
                CFG_GAP_MS:        gap_ms = val[7:0];
                default: ;
            endcase
        endfunction

        function void clear_counters();
            half_cnt = '0;
            ms_cyc   = '0;
            ms_cnt   = '0;
            unit_cnt = '0;
        endfunction

        // One tick of the millisecond prescaler; zero limit behaves as one
        function bit ms_elapsed();
            ms_cyc = ms_cyc + 16'd1;
            if (ms_cyc >= cycles_per_ms || ms_cyc == 16'd0)
            begin
                ms_cyc = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void tick_playback();
            logic [7:0]  note;
            logic [7:0]  len;
            logic [16:0] hp;
            note = score[pos][15:8];
            len  = score[pos][7:0];
            case (phase)
                PH_START:
                begin
                    if (note == END_MARK)
                        ended = 1'b1;
                    else
                    begin
                        note_sel = (note < DEFAULT_NOTE_COUNT) ? note[5:0] : NOTE_REST[5:0];
                        clear_counters();
                        phase = (len == 8'd0) ? PH_GAP : PH_NOTE;
                    end
                end
                PH_NOTE:
                begin
                    // square wave; rests hold the level
                    if (note_sel != 6'd0)
                    begin
                        hp = 17'h10000 - {1'b0, PITCH_RELOAD[note_sel]};
                        half_cnt = half_cnt + 16'd1;
                        if ({1'b0, half_cnt} >= hp)
                        begin
                            half_cnt = '0;
                            wave = ~wave;
                        end
                    end
                    // length is read live from the current entry
                    if (ms_elapsed())
                    begin
                        ms_cnt = ms_cnt + 16'd1;
                        if (ms_cnt >= unit_ms || ms_cnt == 16'd0)
                        begin
                            ms_cnt = '0;
                            unit_cnt = unit_cnt + 8'd1;
                            if (unit_cnt >= len)
                            begin
                                clear_counters();
                                phase = PH_GAP;
                            end
                        end
                    end
                end
                default:
                begin
                    if (ms_cnt >= {8'd0, gap_ms})
                    begin
                        clear_counters();
                        pos = pos + 8'd1;
                        phase = PH_START;
                    end
                    else if (ms_elapsed())
                        ms_cnt = ms_cnt + 16'd1;
                end
            endcase
        endfunction

        // Accepted input word: update state, queue the expected result
        function void play_word(in_word_t w);
            out_word_t want;
            case (w.op)
                OP_LOAD:
                begin
                    score[w.load_addr]  = {w.load_note, w.load_length};
                    loaded[w.load_addr] = 1'b1;
                end
                OP_TICK:
                    if (!ended && !paused)
                        tick_playback();
                OP_RESTART:
                    if (!ended && !paused)
                    begin
                        pos      = '0;
                        note_sel = '0;
                        clear_counters();
                        phase    = PH_START;
                    end
                OP_PAUSE:
                    if (!ended)
                        paused = 1'b1;
                OP_RESUME:
                    if (!ended)
                        paused = 1'b0;
                default: ;
            endcase
            want.buzzer   = wave;
            want.tone_on  = !ended && !paused && phase == PH_NOTE && note_sel != 6'd0;
            want.position = pos;
            want.finished = ended;
            expected_words.push_back(want);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        // Accepted result word against the oldest expectation
        function void check_word(out_word_t got);
            out_word_t want;
            if (expected_words.size() == 0)
            begin
                $error("result word with no expectation pending");
                errors++;
                return;
            end
            want = expected_words.pop_front();
            compare_field("buzzer", 8'(want.buzzer), 8'(got.buzzer));
            compare_field("tone_on", 8'(want.tone_on), 8'(got.tone_on));
            compare_field("position", want.position, got.position);
            compare_field("finished", 8'(want.finished), 8'(got.finished));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_word_t    in_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_word_t   out_word;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_CYCLES_PER_MS;
    logic [15:0] cfg_data = '0;

    bit               allow_idle = 1'b1;
    int               cycle_count = 0;
    int               stall_left = 0;
    melody_scoreboard sb;

    melody_tone_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Result monitor and receiver stall bursts
    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n && out_valid && !out_stall)
            sb.check_word(out_word);
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (allow_idle && $urandom_range(0, 99) < 12)
        begin
            stall_left = $urandom_range(1, 3) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic in_word_t make_word(logic [2:0] op, logic [7:0] addr,
                                           logic [7:0] note, logic [7:0] len);
        in_word_t w;
        w.op          = op;
        w.load_addr   = addr;
        w.load_note   = note;
        w.load_length = len;
        return w;
    endfunction

    function automatic logic [7:0] pick_note();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return 8'($urandom_range(NOTE_PITCH_LO, NOTE_PITCH_HI));
        // high pitches toggle within short notes
        if (r < 45) return 8'($urandom_range(45, NOTE_PITCH_HI));
        if (r < 65) return NOTE_REST;
        if (r < 80) return 8'($urandom_range(DEFAULT_NOTE_COUNT, NOTE_UNKNOWN_HI));
        if (r < 90) return END_MARK;
        return 8'($urandom);
    endfunction

    // Next command word, shaped by the predicted playback state
    function automatic in_word_t pick_word(int len_max, bit sweep, bit end_ok);
        in_word_t   w;
        int         r;
        logic [7:0] addr;
        logic [7:0] note;
        logic [7:0] len;
        r = $urandom_range(0, 99);
        // loads mostly land at or just ahead of the playing entry
        addr = ($urandom_range(0, 9) < 7) ? sb.pos + 8'($urandom_range(0, 3)) : 8'($urandom);
        note = pick_note();
        len  = (!sweep && $urandom_range(0, 19) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(0, len_max));
        w = make_word(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
        if (sb.paused && r < 35)
            w.op = OP_RESUME;
        else if (sweep)
        begin
            if (r < 94)      w.op = OP_TICK;
            else if (r < 97) w = make_word(OP_LOAD, addr, note, len);
            else if (r < 98) w.op = OP_PAUSE;
            else if (r < 99) w.op = OP_RESUME;
            else             w.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        end
        else
        begin
            if (r < 66)      w.op = OP_TICK;
            else if (r < 80) w = make_word(OP_LOAD, addr, note, len);
            else if (r < 86) w.op = OP_RESTART;
            else if (r < 91) w.op = OP_PAUSE;
            else if (r < 96) w.op = OP_RESUME;
            else             w.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        end
        // a tick must not fetch an unloaded entry, nor hit the end mark too early
        if (w.op == OP_TICK && !sb.ended && !sb.paused && sb.phase != PH_GAP &&
            (!sb.loaded[sb.pos] ||
             (!end_ok && sb.phase == PH_START && sb.score[sb.pos][15:8] == END_MARK)))
        begin
            if (!end_ok && note == END_MARK)
                note = NOTE_REST;
            w = make_word(OP_LOAD, sb.pos, note, len);
        end
        return w;
    endfunction

    task automatic send_word(input in_word_t w);
        if (allow_idle && $urandom_range(0, 99) < 15)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        sb.play_word(w);
    endtask

    // Hold off the sender until every expected word has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.expected_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_settings(input logic [15:0] cpm, input logic [15:0] unit,
                                  input logic [15:0] gap);
        logic [15:0] vals [3];
        cfg_index_t  idx;
        vals = '{cpm, unit, gap};
        for (int i = 0; i < 3; i++)
        begin
            idx = cfg_index_t'(i);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            sb.set_reg(idx, vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_segment(input logic [15:0] cpm, input logic [15:0] unit,
                               input logic [15:0] gap, input int count,
                               input int len_max, input bit end_ok);
        wait_drained();
        write_settings(cpm, unit, gap);
        repeat (count) send_word(pick_word(len_max, 1'b0, end_ok));
    endtask

    initial
    begin
        logic [7:0] last_pos;
        logic [7:0] note;
        bit         wrapped;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, every op, pause semantics, default timing
        send_word(make_word(OP_LOAD, 8'd0, NOTE_PITCH_LO, 8'hFF));
        send_word(make_word(OP_LOAD, 8'd1, NOTE_PITCH_HI, 8'd1));
        send_word(make_word(OP_LOAD, 8'd2, NOTE_REST, 8'd2));
        send_word(make_word(OP_LOAD, 8'd3, 8'(DEFAULT_NOTE_COUNT), 8'd1));
        send_word(make_word(OP_LOAD, 8'd4, NOTE_UNKNOWN_HI, 8'd0));
        send_word(make_word(OP_LOAD, 8'hFF, END_MARK, 8'hFF));
        send_word(make_word(OP_TICK, 8'h00, 8'h00, 8'h00));
        send_word(make_word(OP_TICK, 8'hFF, 8'hFF, 8'hFF));
        send_word(make_word(OP_TICK, 8'h00, 8'h00, 8'h00));
        send_word(make_word(OP_PAUSE, 8'h00, 8'h00, 8'h00));
        send_word(make_word(OP_TICK, 8'h00, 8'h00, 8'h00));
        send_word(make_word(OP_RESTART, 8'h00, 8'h00, 8'h00));
        send_word(make_word(OP_RESUME, 8'h00, 8'h00, 8'h00));
        send_word(make_word(OP_TICK, 8'h00, 8'h00, 8'h00));
        send_word(make_word(OP_RESTART, 8'h00, 8'h00, 8'h00));
        send_word(make_word(OP_SPARE_LO, 8'hA5, 8'h5A, 8'hC3));
        send_word(make_word(OP_SPARE_HI, 8'hFF, 8'hFF, 8'hFF));
        send_word(make_word(OP_TICK, 8'h00, 8'h00, 8'h00));

        // Fill the whole score, mostly zero-length entries
        wait_drained();
        write_settings(16'd4, 16'd2, 16'd1);
        for (int a = 0; a < STORE_DEPTH; a++)
        begin
            note = pick_note();
            if (note == END_MARK)
                note = NOTE_REST;
            send_word(make_word(OP_LOAD, 8'(a), note,
                                ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 3)) : 8'd0));
        end

        // Fastest timing: play through until the position wraps
        wait_drained();
        write_settings(16'd1, 16'd1, 16'd0);
        wrapped = 1'b0;
        while (!wrapped)
        begin
            last_pos = sb.pos;
            send_word(pick_word(0, 1'b1, 1'b0));
            wrapped = sb.pos < last_pos;
        end

        // Notes long enough for the wave to toggle
        run_segment(16'd16, 16'd4, 16'd1, 60, 4, 1'b0);
        // Register extremes
        run_segment(16'hFFFF, 16'hFFFF, 16'd255, 20, 3, 1'b0);
        run_segment(16'd0, 16'd0, 16'd0, 25, 3, 1'b0);
        // Small random timing; junk in the unused upper gap bits
        run_segment(16'($urandom_range(1, 6)), 16'($urandom_range(1, 4)),
                    {8'($urandom), 8'($urandom_range(0, 3))}, 25, 3, 1'b0);
        // Last part: no idling, end mark allowed
        allow_idle = 1'b0;
        run_segment(16'd2, 16'd2, 16'd1, 50, 3, 1'b1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
